/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the derating coefficient unit.
// No dependencies; included by the files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("implication assertion failed");

// The expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
    else $error("never assertion failed");

`endif

/* rtl/mcdcu_pkg.sv */
// Package of the multi-channel derating coefficient unit: constants, register
// codes and the transaction structs shared by all modules. No dependencies.
package mcdcu_pkg;

  localparam int unsigned CHANNELS    = 8;
  localparam int unsigned MASK_W      = 8;
  localparam int unsigned LEVEL_W     = 16;
  localparam int unsigned Q_SHIFT     = 15;
  localparam int unsigned CNT_W       = 4;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [LEVEL_W-1:0] FULL_SCALE = 16'h8000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE_MASK = 2'd0,
    REG_INVERT_MASK = 2'd1,
    REG_RISE_STEP   = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [2:0]         channel;
    logic [LEVEL_W-1:0] sample;
    logic [LEVEL_W-1:0] upper_limit;
    logic [LEVEL_W-1:0] lower_limit;
    logic               last_channel;
  } in_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] channel_level;
    logic [LEVEL_W-1:0] coefficient;
    logic               coefficient_valid;
  } out_t;

  // Classified item as it waits between the front and the back.
  typedef struct packed {
    logic               enabled;
    logic               inverted;
    logic               direct;    // level before inversion is full scale
    logic               last;
    logic [LEVEL_W-1:0] delta;
    logic [LEVEL_W-1:0] span;
  } work_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

/* rtl/mcdcu_front.sv */
// Front of the derating coefficient unit: accepts input transactions and
// classifies them for the divider. Depends on mcdcu_pkg.
module mcdcu_front (
  input  logic                        push_i,
  input  mcdcu_pkg::in_t              in_data_i,
  input  logic [mcdcu_pkg::MASK_W-1:0] enable_mask_i,
  input  logic [mcdcu_pkg::MASK_W-1:0] invert_mask_i,
  input  mcdcu_pkg::q_status_t        q_status_i,
  output logic                        q_push_o,
  output mcdcu_pkg::work_t            work_o
);
  import mcdcu_pkg::*;

  logic               chan_ok;
  logic               enabled;
  logic [LEVEL_W-1:0] span;
  logic [LEVEL_W-1:0] delta;
  logic               bad_span;

  assign q_push_o = push_i && !q_status_i.full;

  assign chan_ok  = 32'(in_data_i.channel) < CHANNELS;
  assign enabled  = chan_ok && enable_mask_i[in_data_i.channel];
  assign bad_span = in_data_i.upper_limit <= in_data_i.lower_limit;
  assign span     = in_data_i.upper_limit - in_data_i.lower_limit;

  always_comb begin
    delta = '0;
    if (in_data_i.sample > in_data_i.lower_limit) begin
      delta = in_data_i.sample - in_data_i.lower_limit;
    end
  end

  // A sample at or above the upper limit maps straight to full scale, so the
  // divider only ever sees a delta below the span.
  always_comb begin
    work_o.enabled  = enabled;
    work_o.inverted = enabled && invert_mask_i[in_data_i.channel];
    work_o.direct   = !enabled || bad_span || (delta >= span);
    work_o.last     = in_data_i.last_channel;
    work_o.delta    = delta;
    work_o.span     = span;
  end

endmodule

/* rtl/mcdcu_queue.sv */
// Short queue between the front and the back of the derating coefficient unit.
// Depends on mcdcu_pkg.
module mcdcu_queue #(
  parameter int unsigned Depth = mcdcu_pkg::QUEUE_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  mcdcu_pkg::work_t     data_i,
  input  logic                 pop_i,
  output mcdcu_pkg::work_t     data_o,
  output mcdcu_pkg::q_status_t status_o
);
  import mcdcu_pkg::*;

  localparam int unsigned PtrW   = $clog2(Depth);
  localparam int unsigned CountW = $clog2(Depth + 1);

  work_t             mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CountW-1:0] count_q, count_d;
  logic              do_push, do_pop;

  assign status_o.full  = count_q == CountW'(Depth);
  assign status_o.empty = count_q == '0;
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

/* rtl/mcdcu_back.sv */
// Back of the derating coefficient unit: serial divider, running minimum,
// rate limiter and the result register. Depends on mcdcu_pkg.
module mcdcu_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mcdcu_pkg::work_t              work_i,
  input  mcdcu_pkg::q_status_t          q_status_i,
  output logic                          q_pop_o,
  input  logic [mcdcu_pkg::LEVEL_W-1:0] rise_step_i,
  input  logic                          pop_i,
  output logic                          empty_o,
  output mcdcu_pkg::out_t               out_data_o
);
  import mcdcu_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]         state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               out_valid_q, out_valid_d;
  logic [LEVEL_W-1:0] run_min_q, run_min_d;
  logic [LEVEL_W-1:0] prev_coeff_q, prev_coeff_d;

  work_t              work_q, work_d;
  logic [LEVEL_W:0]   rem_q, rem_d;
  logic [LEVEL_W-1:0] quo_q, quo_d;
  out_t               out_q, out_d;

  logic [LEVEL_W:0]   rem_sh;
  logic               fire;
  logic [LEVEL_W-1:0] level;
  logic [LEVEL_W-1:0] new_min;
  logic [LEVEL_W:0]   ceiling;
  logic [LEVEL_W-1:0] coeff;

  assign empty_o    = !out_valid_q;
  assign out_data_o = out_q;
  assign q_pop_o    = (state_q == ST_IDLE) && !q_status_i.empty;
  assign fire       = (state_q == ST_FIN) && (!out_valid_q || pop_i);
  assign rem_sh     = {rem_q[LEVEL_W-1:0], 1'b0};

  always_comb begin
    level = work_q.direct ? FULL_SCALE : quo_q;
    if (work_q.inverted) begin
      level = FULL_SCALE - level;
    end
    new_min = run_min_q;
    if (work_q.enabled && (level < run_min_q)) begin
      new_min = level;
    end
    // The sum is one bit wider so that the limit compare cannot wrap.
    ceiling = {1'b0, prev_coeff_q} + {1'b0, rise_step_i};
    coeff   = ({1'b0, new_min} > ceiling) ? ceiling[LEVEL_W-1:0] : new_min;
  end

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    out_valid_d  = out_valid_q;
    run_min_d    = run_min_q;
    prev_coeff_d = prev_coeff_q;
    work_d       = work_q;
    rem_d        = rem_q;
    quo_d        = quo_q;
    out_d        = out_q;

    if (pop_i && out_valid_q) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (q_pop_o) begin
          work_d = work_i;
          rem_d  = {1'b0, work_i.delta};
          quo_d  = '0;
          cnt_d  = '0;
          state_d = work_i.direct ? ST_FIN : ST_DIV;
        end
      end
      ST_DIV: begin
        // Restoring division, one quotient bit per cycle.
        if (rem_sh >= {1'b0, work_q.span}) begin
          rem_d = rem_sh - {1'b0, work_q.span};
          quo_d = {quo_q[LEVEL_W-2:0], 1'b1};
        end else begin
          rem_d = rem_sh;
          quo_d = {quo_q[LEVEL_W-2:0], 1'b0};
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(Q_SHIFT - 1)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (fire) begin
          out_valid_d = 1'b1;
          out_d.channel_level     = level;
          out_d.coefficient       = '0;
          out_d.coefficient_valid = work_q.last;
          run_min_d = new_min;
          if (work_q.last) begin
            out_d.coefficient = coeff;
            prev_coeff_d      = coeff;
            run_min_d         = FULL_SCALE;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
      run_min_q    <= FULL_SCALE;
      prev_coeff_q <= '0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      out_valid_q  <= out_valid_d;
      run_min_q    <= run_min_d;
      prev_coeff_q <= prev_coeff_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    out_q  <= out_d;
  end

endmodule

/* rtl/multi_channel_derating_coefficient_unit.sv */
// Multi-channel derating coefficient unit: top level with the register file.
// Depends on mcdcu_pkg, mcdcu_front, mcdcu_queue, mcdcu_back, assert_macros.svh.
//
// Each input transaction gives one channel's Q15 level, and the transaction
// marked last also gives the rate-limited coefficient. An enabled channel with a
// positive range and a sample below its upper limit is taken from the queue, goes
// through the radix-2 serial divider (one quotient bit per cycle) and is finished
// once the result register is free; others skip the divider. The front accepts
// transactions while the back is dividing, until the queue of QueueDepth entries
// is full. Registers are written through the always-ready configuration channel;
// the user must write them only while the unit is idle; the block does not check.
`include "assert_macros.svh"

module multi_channel_derating_coefficient_unit #(
  parameter int unsigned QueueDepth = mcdcu_pkg::QUEUE_DEPTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  output logic                              full,
  input  mcdcu_pkg::in_t                    in_data_i,
  output logic                              empty,
  input  logic                              pop,
  output mcdcu_pkg::out_t                   out_data_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [mcdcu_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [mcdcu_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import mcdcu_pkg::*;

  logic [MASK_W-1:0]  enable_mask_q, enable_mask_d;
  logic [MASK_W-1:0]  invert_mask_q, invert_mask_d;
  logic [LEVEL_W-1:0] rise_step_q, rise_step_d;

  q_status_t q_status;
  work_t     front_work;
  work_t     queue_work;
  logic      q_push;
  logic      q_pop;

  assign cfg_ready_o = 1'b1;
  assign full        = q_status.full;

  always_comb begin
    enable_mask_d = enable_mask_q;
    invert_mask_d = invert_mask_q;
    rise_step_d   = rise_step_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_ENABLE_MASK: enable_mask_d = cfg_data_i[MASK_W-1:0];
        REG_INVERT_MASK: invert_mask_d = cfg_data_i[MASK_W-1:0];
        REG_RISE_STEP:   rise_step_d   = cfg_data_i[LEVEL_W-1:0];
        default: begin
          rise_step_d = rise_step_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_mask_q <= '0;
      invert_mask_q <= '0;
      rise_step_q   <= FULL_SCALE;
    end else begin
      enable_mask_q <= enable_mask_d;
      invert_mask_q <= invert_mask_d;
      rise_step_q   <= rise_step_d;
    end
  end

  mcdcu_front u_front (
    .push_i        (push),
    .in_data_i     (in_data_i),
    .enable_mask_i (enable_mask_q),
    .invert_mask_i (invert_mask_q),
    .q_status_i    (q_status),
    .q_push_o      (q_push),
    .work_o        (front_work)
  );

  mcdcu_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (q_push),
    .data_i   (front_work),
    .pop_i    (q_pop),
    .data_o   (queue_work),
    .status_o (q_status)
  );

  mcdcu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .work_i      (queue_work),
    .q_status_i  (q_status),
    .q_pop_o     (q_pop),
    .rise_step_i (rise_step_q),
    .pop_i       (pop),
    .empty_o     (empty),
    .out_data_o  (out_data_o)
  );

  // Levels and coefficients never exceed full scale, and a coefficient is only
  // reported on the transaction that closes a round.
  `ASSERT_IMPLIES(a_level_range, clk_i, rst_ni, !empty, out_data_o.channel_level <= FULL_SCALE)
  `ASSERT_IMPLIES(a_coeff_range, clk_i, rst_ni, !empty, out_data_o.coefficient <= FULL_SCALE)
  `ASSERT_IMPLIES(a_coeff_zero, clk_i, rst_ni, !empty && !out_data_o.coefficient_valid,
                  out_data_o.coefficient == '0)
  `ASSERT_NEVER(a_pop_from_empty, clk_i, rst_ni, q_pop && q_status.empty)

endmodule

/* bench/derating_checker.sv */
// Checker for the multi-channel derating coefficient unit: watches the input, result and
// register channels, predicts each result and compares it field by field.
// Depends on mcdcu_pkg only.
module derating_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push,
  input  logic                             full,
  input  mcdcu_pkg::in_t                   in_data_i,
  input  logic                             empty,
  input  logic                             pop,
  input  mcdcu_pkg::out_t                  out_data_i,
  input  logic                             cfg_valid_i,
  input  logic                             cfg_ready_i,
  input  logic [mcdcu_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [mcdcu_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned                      error_count_o,
  output int unsigned                      outstanding_o
);
  import mcdcu_pkg::*;

  logic [MASK_W-1:0]  enable_mask;
  logic [MASK_W-1:0]  invert_mask;
  logic [LEVEL_W-1:0] rise_step;
  logic [LEVEL_W-1:0] running_min;
  logic [LEVEL_W-1:0] prev_coeff;

  out_t        expected_results[$];
  out_t        oldest;
  int unsigned errors;

  // Works out the result of one transaction and advances the round state.
  function automatic out_t derate(in_t item);
    out_t        res;
    logic [31:0] span;
    logic [31:0] delta;
    logic [31:0] ceiling;
    logic [15:0] level;
    level = FULL_SCALE;
    if (enable_mask[item.channel]) begin
      if (item.upper_limit > item.lower_limit) begin
        span  = item.upper_limit - item.lower_limit;
        delta = (item.sample > item.lower_limit) ? item.sample - item.lower_limit : 32'd0;
        if (delta > span) delta = span;
        level = 16'((delta << Q_SHIFT) / span);
      end
      if (invert_mask[item.channel]) level = FULL_SCALE - level;
      if (level < running_min) running_min = level;
    end
    res.channel_level     = level;
    res.coefficient       = '0;
    res.coefficient_valid = item.last_channel;
    if (item.last_channel) begin
      // The ceiling is formed at full width so that it cannot wrap.
      ceiling = {16'd0, prev_coeff} + {16'd0, rise_step};
      res.coefficient = ({16'd0, running_min} > ceiling) ? 16'(ceiling) : running_min;
      prev_coeff  = res.coefficient;
      running_min = FULL_SCALE;
    end
    return res;
  endfunction

  task automatic compare_field(input string field, input logic [15:0] want,
                               input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_mask = '0;
      invert_mask = '0;
      rise_step   = FULL_SCALE;
      running_min = FULL_SCALE;
      prev_coeff  = '0;
      expected_results.delete();
      errors = 0;
      error_count_o <= 0;
      outstanding_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_ENABLE_MASK: enable_mask = cfg_data_i[MASK_W-1:0];
          REG_INVERT_MASK: invert_mask = cfg_data_i[MASK_W-1:0];
          REG_RISE_STEP:   rise_step   = cfg_data_i;
          default: ;
        endcase
      end
      if (push && !full) expected_results.push_back(derate(in_data_i));
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual level %0d coefficient %0d",
                   $time, out_data_i.channel_level, out_data_i.coefficient);
          errors++;
        end else begin
          oldest = expected_results.pop_front();
          compare_field("channel_level", oldest.channel_level, out_data_i.channel_level);
          compare_field("coefficient", oldest.coefficient, out_data_i.coefficient);
          compare_field("coefficient_valid", 16'(oldest.coefficient_valid),
                        16'(out_data_i.coefficient_valid));
        end
      end
      error_count_o <= errors;
      outstanding_o <= expected_results.size();
    end
  end

endmodule

/* bench/tb_multi_channel_derating_coefficient_unit.sv */
// Testbench top of the multi-channel derating coefficient unit: clock, reset, stimulus
// and verdict. Depends on mcdcu_pkg, derating_checker and the unit itself.
module tb_multi_channel_derating_coefficient_unit;
  import mcdcu_pkg::*;

  localparam int unsigned           CYCLE_LIMIT  = 200000;
  localparam int unsigned           PHASE_ITEMS  = 110;
  localparam int unsigned           PHASES       = 5;
  localparam logic [CFG_IDX_W-1:0]  REG_UNMAPPED = 2'd3;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  push;
  logic                  full;
  in_t                   in_data;
  logic                  empty;
  logic                  pop = 1'b0;
  out_t                  out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int unsigned errors;
  int unsigned outstanding;
  int unsigned cycles = 0;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  multi_channel_derating_coefficient_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_data_i   (in_data),
    .empty       (empty),
    .pop         (pop),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  derating_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .in_data_i     (in_data),
    .empty         (empty),
    .pop           (pop),
    .out_data_i    (out_data),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .error_count_o (errors),
    .outstanding_o (outstanding)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    pop <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic in_t make_item(logic [2:0] channel, logic [15:0] sample,
                                    logic [15:0] upper, logic [15:0] lower, logic last);
    in_t item;
    item.channel      = channel;
    item.sample       = sample;
    item.upper_limit  = upper;
    item.lower_limit  = lower;
    item.last_channel = last;
    return item;
  endfunction

  function automatic logic [15:0] corner_value();
    case ($urandom_range(0, 3))
      0:       return 16'h0000;
      1:       return 16'h0001;
      2:       return 16'h8000;
      default: return 16'hFFFF;
    endcase
  endfunction

  // Mostly samples within sane limits, limits included, so that the divider is exercised,
  // with clamped, degenerate-range, corner and fully random transactions mixed in.
  function automatic in_t random_item(logic last);
    in_t         item;
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] lo;
    logic [15:0] hi;
    a = 16'($urandom);
    b = 16'($urandom);
    if (a == b) b = a ^ 16'h0001;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    item.channel      = 3'($urandom_range(0, 7));
    item.last_channel = last;
    item.lower_limit  = lo;
    item.upper_limit  = hi;
    case ($urandom_range(0, 9))
      6: item.sample = $urandom_range(0, 1) ? 16'($urandom_range(0, lo))
                                            : 16'($urandom_range(hi, 16'hFFFF));
      7: begin
        item.upper_limit = lo;
        item.lower_limit = $urandom_range(0, 1) ? lo : hi;
        item.sample      = 16'($urandom);
      end
      8: begin
        item.sample      = 16'($urandom);
        item.upper_limit = 16'($urandom);
        item.lower_limit = 16'($urandom);
      end
      9: begin
        item.sample      = corner_value();
        item.upper_limit = corner_value();
        item.lower_limit = corner_value();
      end
      default: item.sample = lo + 16'($urandom_range(0, hi - lo));
    endcase
    return item;
  endfunction

  // The sender idles cycle by cycle before offering the transaction, then holds it
  // until it is taken.
  task automatic send_item(input in_t item);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push    <= 1'b1;
    in_data <= item;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
  endtask

  task automatic drain();
    push <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    int unsigned phase_count;
    int unsigned round_len;
    logic        noisy;
    logic        paused;

    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    push           = 1'b0;
    in_data        = '0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    paused         = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Every channel is disabled after reset, so the levels are full scale.
    send_item(make_item(3'd0, 16'd1000, 16'd2000, 16'd0, 1'b0));
    send_item(make_item(3'd7, 16'hFFFF, 16'hFFFF, 16'd0, 1'b1));
    drain();
    write_reg(REG_ENABLE_MASK, 16'hABFF);
    write_reg(REG_INVERT_MASK, 16'h55F0);
    write_reg(REG_UNMAPPED, 16'hFFFF);

    send_item(make_item(3'd0, 16'd1500, 16'd2000, 16'd1000, 1'b0));
    send_item(make_item(3'd1, 16'd5, 16'd2000, 16'd1000, 1'b0));      // below the lower limit
    send_item(make_item(3'd2, 16'hFFFF, 16'd2000, 16'd1000, 1'b0));   // above the upper limit
    send_item(make_item(3'd3, 16'd500, 16'd700, 16'd700, 1'b0));      // zero range
    send_item(make_item(3'd4, 16'd500, 16'd100, 16'd700, 1'b0));      // negative range, inverted
    send_item(make_item(3'd5, 16'd1000, 16'd2000, 16'd1000, 1'b0));
    send_item(make_item(3'd6, 16'd0, 16'hFFFF, 16'd0, 1'b0));
    send_item(make_item(3'd7, 16'hFFFE, 16'hFFFF, 16'd0, 1'b1));
    drain();

    // A zero rise step keeps the coefficient from rising above where it is.
    write_reg(REG_RISE_STEP, 16'd0);
    send_item(make_item(3'd0, 16'd2000, 16'd2000, 16'd0, 1'b1));
    drain();
    write_reg(REG_RISE_STEP, 16'd100);
    send_item(make_item(3'd0, 16'hFFFF, 16'hFFFF, 16'd0, 1'b1));
    send_item(make_item(3'd1, 16'd1, 16'd2, 16'd0, 1'b1));
    drain();

    // With the largest step the ceiling goes past 16 bits and must not wrap.
    write_reg(REG_RISE_STEP, 16'hFFFF);
    send_item(make_item(3'd2, 16'd40000, 16'd30000, 16'd20000, 1'b1));
    send_item(make_item(3'd3, 16'd0, 16'd0, 16'd0, 1'b1));
    drain();
    write_reg(REG_ENABLE_MASK, 16'h000F);
    send_item(make_item(3'd5, 16'd0, 16'd100, 16'd0, 1'b0));
    send_item(make_item(3'd1, 16'd0, 16'd100, 16'd0, 1'b1));
    drain();

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          write_reg(REG_ENABLE_MASK, 16'h00FF);
          write_reg(REG_RISE_STEP, FULL_SCALE);
        end
        1: begin
          send_idle_pct  = 62;
          recv_stall_pct = 0;
          write_reg(REG_ENABLE_MASK, 16'($urandom));
          write_reg(REG_RISE_STEP, 16'($urandom_range(1, 500)));
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 62;
          write_reg(REG_ENABLE_MASK, 16'($urandom));
          write_reg(REG_RISE_STEP, 16'($urandom_range(0, 32768)));
        end
        3: begin
          send_idle_pct  = 14;
          recv_stall_pct = 14;
          write_reg(REG_ENABLE_MASK, 16'($urandom));
          write_reg(REG_RISE_STEP, 16'd0);
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          write_reg(REG_ENABLE_MASK, 16'($urandom));
          write_reg(REG_RISE_STEP, 16'hFFFF);
        end
      endcase
      write_reg(REG_INVERT_MASK, 16'($urandom));

      phase_count = 0;
      while (phase_count < PHASE_ITEMS) begin
        // Most rounds end on their final transaction; a few carry random last flags.
        round_len = $urandom_range(1, 8);
        noisy     = ($urandom_range(0, 9) == 0);
        for (int k = 0; k < round_len; k++) begin
          send_item(random_item(noisy ? 1'($urandom_range(0, 1)) : (k == round_len - 1)));
          phase_count++;
        end
        if (phase == 1 && !paused && phase_count >= 50) begin
          paused = 1'b1;
          drain();
        end
      end
      drain();
    end

    repeat (40) @(posedge clk_i);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* multi_channel_derating_coefficient_unit.f */
+incdir+rtl
rtl/mcdcu_pkg.sv
rtl/mcdcu_front.sv
rtl/mcdcu_queue.sv
rtl/mcdcu_back.sv
rtl/multi_channel_derating_coefficient_unit.sv
bench/derating_checker.sv
bench/tb_multi_channel_derating_coefficient_unit.sv
